/* design/lffm_pkg.sv */
// shared types and constants for the line follower fault monitor
// event kinds, fault codes, register indexes and the command word that
// travels from the front to the back; no dependencies
package lffm_pkg;

	// default datapath widths
	localparam int POSITION_WIDTH_DEF = 16;
	localparam int SPEED_WIDTH_DEF    = 16;

	// configuration port
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	// register widths
	localparam int LOST_W    = 15;
	localparam int FROZEN_W  = 16;
	localparam int RPM_W     = 15;
	localparam int TIMEOUT_W = 16;
	localparam int ELAPSED_W = 16;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LOST_THRESHOLD = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FROZEN_LIMIT   = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RPM        = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT  = 8'd3;

	// register reset values
	localparam logic [LOST_W-1:0]    LOST_THRESHOLD_RST = 15'd4096;
	localparam logic [FROZEN_W-1:0]  FROZEN_LIMIT_RST   = 16'd10;
	localparam logic [RPM_W-1:0]     MAX_RPM_RST        = 15'd3000;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_LIMIT_RST  = 16'd500;

	// frozen run counter
	localparam int                  RUN_W   = 17;
	localparam logic [RUN_W-1:0]    RUN_MAX = 17'h1FFFF;

	// command queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_UPDATE  = 2'd0,
		MODE_TIMEOUT = 2'd1,
		MODE_ESTOP   = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		FAULT_NONE      = 3'd0,
		FAULT_ESTOP     = 3'd1,
		FAULT_DROPOUT   = 3'd2,
		FAULT_LINE_LOST = 3'd3,
		FAULT_MOTOR_SAT = 3'd4,
		FAULT_TIMEOUT   = 3'd5
	} fault_code_t;

	// classified event: threshold checks already resolved by the front
	typedef struct packed {
		mode_t mode;
		logic  detect;
		logic  lost;
		logic  sat;
		logic  timeout;
		logic  level;
	} lffm_cmd_t;

	// queue occupancy as seen by the neighbors
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} lffm_q_status_t;

endpackage

/* design/line_follow_fault_monitor.sv */
// top level of the line follower fault monitor
// configuration registers, front, command queue and back; uses lffm_pkg

// Sticky fault monitor for a line follower. Each transfer on the input
// channel is one event (update, timeout check, e-stop level, clear) and
// gives exactly one result: the fault flag, fault code and e-stop latch as
// they stand after that event. One event is taken per clock cycle while
// in_ready is high; a result passes the front stage, the two-entry command
// queue and the result register, in that order, and back-pressure on the
// output stalls the chain. Registers are written through the
// configuration channel, which is always ready; indexes beyond the
// register list are ignored and unused high data bits are dropped.
module line_follow_fault_monitor #(
	parameter int POSITION_WIDTH = lffm_pkg::POSITION_WIDTH_DEF,
	parameter int SPEED_WIDTH    = lffm_pkg::SPEED_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lffm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lffm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic signed [POSITION_WIDTH-1:0]  track_pos,
	input  logic                              track_detect,
	input  logic signed [SPEED_WIDTH-1:0]     left_rpm,
	input  logic signed [SPEED_WIDTH-1:0]     right_rpm,
	input  logic [lffm_pkg::ELAPSED_W-1:0]    elapsed_ms,
	input  logic                              estop_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              has_fault,
	output logic [2:0]                        fault_code,
	output logic                              estop_active
);
	import lffm_pkg::*;

	localparam int QW = $bits(lffm_cmd_t) + POSITION_WIDTH;

	logic [LOST_W-1:0]    lost_threshold_q;
	logic [FROZEN_W-1:0]  frozen_limit_q;
	logic [RPM_W-1:0]     max_rpm_q;
	logic [TIMEOUT_W-1:0] timeout_limit_q;

	logic                      push_valid;
	logic                      push_ready;
	lffm_cmd_t                 push_cmd;
	logic [POSITION_WIDTH-1:0] push_pos;
	logic                      pop_valid;
	logic                      pop_ready;
	logic [QW-1:0]             pop_data;
	lffm_cmd_t                 pop_cmd;
	logic [POSITION_WIDTH-1:0] pop_pos;
	lffm_q_status_t            q_status;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_threshold_q <= LOST_THRESHOLD_RST;
			frozen_limit_q   <= FROZEN_LIMIT_RST;
			max_rpm_q        <= MAX_RPM_RST;
			timeout_limit_q  <= TIMEOUT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOST_THRESHOLD: lost_threshold_q <= cfg_data[LOST_W-1:0];
				REG_FROZEN_LIMIT:   frozen_limit_q   <= cfg_data[FROZEN_W-1:0];
				REG_MAX_RPM:        max_rpm_q        <= cfg_data[RPM_W-1:0];
				REG_TIMEOUT_LIMIT:  timeout_limit_q  <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// event intake and classification
	lffm_front #(
		.POSITION_WIDTH (POSITION_WIDTH),
		.SPEED_WIDTH    (SPEED_WIDTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.track_pos        (track_pos),
		.track_detect     (track_detect),
		.left_rpm         (left_rpm),
		.right_rpm        (right_rpm),
		.elapsed_ms       (elapsed_ms),
		.estop_level      (estop_level),
		.lost_threshold   (lost_threshold_q),
		.max_rpm          (max_rpm_q),
		.timeout_limit_ms (timeout_limit_q),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_cmd         (push_cmd),
		.push_pos         (push_pos)
	);

	// command queue
	lffm_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_cmd, push_pos}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.status     (q_status)
	);

	assign pop_cmd = lffm_cmd_t'(pop_data[QW-1:POSITION_WIDTH]);
	assign pop_pos = pop_data[POSITION_WIDTH-1:0];

	// fault state and results
	lffm_back #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.pop_pos      (pop_pos),
		.frozen_limit (frozen_limit_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.has_fault    (has_fault),
		.fault_code   (fault_code),
		.estop_active (estop_active)
	);

	// a delivered result has a fault code exactly when the fault is set
	a_code_matches_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_fault == (fault_code != FAULT_NONE)))
		else $error("fault code and fault flag disagree");

	// a latched e-stop always comes with a sticky fault
	a_estop_implies_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && estop_active) |-> has_fault)
		else $error("e-stop latched without fault");

	// queue fill level stays within its depth and matches its empty flag
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.count <= QCNT_W'(QUEUE_DEPTH)) &&
		(q_status.empty == (q_status.count == '0)))
		else $error("command queue level out of range");

	// the queue never accepts a push while it is full
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push_ready)
		else $error("push accepted into a full queue");

endmodule

/* design/lffm_front.sv */
// front of the fault monitor: accepts events and classifies them
// magnitude and threshold compares, one register stage; uses lffm_pkg
module lffm_front #(
	parameter int POSITION_WIDTH = 16,
	parameter int SPEED_WIDTH    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic signed [POSITION_WIDTH-1:0]  track_pos,
	input  logic                              track_detect,
	input  logic signed [SPEED_WIDTH-1:0]     left_rpm,
	input  logic signed [SPEED_WIDTH-1:0]     right_rpm,
	input  logic [lffm_pkg::ELAPSED_W-1:0]    elapsed_ms,
	input  logic                              estop_level,
	input  logic [lffm_pkg::LOST_W-1:0]       lost_threshold,
	input  logic [lffm_pkg::RPM_W-1:0]        max_rpm,
	input  logic [lffm_pkg::TIMEOUT_W-1:0]    timeout_limit_ms,
	output logic                              push_valid,
	input  logic                              push_ready,
	output lffm_pkg::lffm_cmd_t               push_cmd,
	output logic [POSITION_WIDTH-1:0]         push_pos
);
	import lffm_pkg::*;

	localparam int PC = (POSITION_WIDTH > LOST_W) ? POSITION_WIDTH : LOST_W;
	localparam int SC = (SPEED_WIDTH > RPM_W) ? SPEED_WIDTH : RPM_W;

	logic [POSITION_WIDTH-1:0] pos_mag;
	logic [SPEED_WIDTH-1:0]    left_mag;
	logic [SPEED_WIDTH-1:0]    right_mag;
	lffm_cmd_t                 cmd;

	logic                      valid_s1;
	lffm_cmd_t                 cmd_s1;
	logic [POSITION_WIDTH-1:0] pos_s1;

	// exact magnitudes, the most negative value fits unsigned
	always_comb begin
		pos_mag   = track_pos[POSITION_WIDTH-1] ? (~track_pos + 1'b1) : track_pos;
		left_mag  = left_rpm[SPEED_WIDTH-1] ? (~left_rpm + 1'b1) : left_rpm;
		right_mag = right_rpm[SPEED_WIDTH-1] ? (~right_rpm + 1'b1) : right_rpm;
	end

	// classify the event
	always_comb begin
		cmd.mode    = mode_t'(mode);
		cmd.detect  = track_detect;
		cmd.lost    = PC'(pos_mag) > PC'(lost_threshold);
		cmd.sat     = (SC'(left_mag) > SC'(max_rpm)) || (SC'(right_mag) > SC'(max_rpm));
		cmd.timeout = elapsed_ms > timeout_limit_ms;
		cmd.level   = estop_level;
	end

	// stage register, refilled whenever it empties into the queue
	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			pos_s1 <= track_pos;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;
	assign push_pos   = pos_s1;

endmodule

/* design/lffm_queue.sv */
// short command queue between the front and the back of the fault monitor
// fixed depth from lffm_pkg, payload width as a parameter; uses lffm_pkg
module lffm_queue #(
	parameter int WIDTH = 23
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  logic [WIDTH-1:0]        push_data,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output logic [WIDTH-1:0]        pop_data,
	output lffm_pkg::lffm_q_status_t status
);
	import lffm_pkg::*;

	logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;

	assign push_ready = !status.full;
	assign pop_valid  = !status.empty;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/lffm_back.sv */
// back of the fault monitor: sticky fault state, frozen run counter and
// the result register; takes classified commands; uses lffm_pkg
module lffm_back #(
	parameter int POSITION_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  lffm_pkg::lffm_cmd_t            pop_cmd,
	input  logic [POSITION_WIDTH-1:0]      pop_pos,
	input  logic [lffm_pkg::FROZEN_W-1:0]  frozen_limit,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           has_fault,
	output logic [2:0]                     fault_code,
	output logic                           estop_active
);
	import lffm_pkg::*;

	logic                      fault_flag_q;
	fault_code_t               fault_kind_q;
	logic                      estop_latch_q;
	logic [POSITION_WIDTH-1:0] last_pos_q;
	logic [RUN_W-1:0]          run_q;

	logic                      fault_flag_d;
	fault_code_t               fault_kind_d;
	logic                      estop_latch_d;
	logic [POSITION_WIDTH-1:0] last_pos_d;
	logic [RUN_W-1:0]          run_d;

	logic                      valid_q;
	logic                      take;

	assign pop_ready = !valid_q || out_ready;
	assign take      = pop_valid && pop_ready;

	// next state for one event, later checks overwrite the code
	always_comb begin
		fault_flag_d  = fault_flag_q;
		fault_kind_d  = fault_kind_q;
		estop_latch_d = estop_latch_q;
		last_pos_d    = last_pos_q;
		run_d         = run_q;
		unique case (pop_cmd.mode)
			MODE_UPDATE: begin
				if (estop_latch_q) begin
					fault_flag_d = 1'b1;
					fault_kind_d = FAULT_ESTOP;
				end else begin
					if (pop_cmd.detect) begin
						if (pop_pos == last_pos_q) begin
							run_d = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
						end else begin
							run_d = '0;
						end
						last_pos_d = pop_pos;
					end else begin
						run_d = '0;
					end
					if (run_d > RUN_W'(frozen_limit)) begin
						fault_flag_d = 1'b1;
						fault_kind_d = FAULT_DROPOUT;
					end
					if (!pop_cmd.detect || pop_cmd.lost) begin
						fault_flag_d = 1'b1;
						fault_kind_d = FAULT_LINE_LOST;
					end
					if (pop_cmd.sat) begin
						fault_flag_d = 1'b1;
						fault_kind_d = FAULT_MOTOR_SAT;
					end
				end
			end
			MODE_TIMEOUT: begin
				if (estop_latch_q) begin
					fault_flag_d = 1'b1;
					fault_kind_d = FAULT_ESTOP;
				end else if (pop_cmd.timeout) begin
					fault_flag_d = 1'b1;
					fault_kind_d = FAULT_TIMEOUT;
				end
			end
			MODE_ESTOP: begin
				estop_latch_d = pop_cmd.level;
				if (pop_cmd.level) begin
					fault_flag_d = 1'b1;
					fault_kind_d = FAULT_ESTOP;
				end
			end
			MODE_CLEAR: begin
				fault_flag_d  = 1'b0;
				fault_kind_d  = FAULT_NONE;
				estop_latch_d = 1'b0;
				run_d         = '0;
			end
		endcase
	end

	// monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_flag_q  <= 1'b0;
			fault_kind_q  <= FAULT_NONE;
			estop_latch_q <= 1'b0;
			last_pos_q    <= '0;
			run_q         <= '0;
		end else if (take) begin
			fault_flag_q  <= fault_flag_d;
			fault_kind_q  <= fault_kind_d;
			estop_latch_q <= estop_latch_d;
			last_pos_q    <= last_pos_d;
			run_q         <= run_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			has_fault    <= fault_flag_d;
			fault_code   <= fault_kind_d;
			estop_active <= estop_latch_d;
		end
	end

	assign out_valid = valid_q;

endmodule
